FILE: hw/rtl/pmm_pkg.sv
package pmm_pkg;

	// Coefficient and command widths.
	localparam int CoefW = 26;
	localparam int CmdW  = 2;
	localparam int BitW  = 5;

	// Index of the most significant coefficient bit, where every serial pass starts.
	localparam logic [BitW-1:0] TopBit = BitW'(CoefW - 1);

	// Smallest modulus that is accepted. A smaller written value is raised to it.
	localparam logic [CoefW-1:0] MinModulus = CoefW'(2);
	localparam logic [CoefW-1:0] CoefOne    = CoefW'(1);

	// Command codes.
	localparam logic [CmdW-1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [CmdW-1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [CmdW-1:0] CMD_START       = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP,
		ST_PREP_DONE,
		ST_MUL,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	// Controls broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic            clr_r;     // restart the serial modular product
		logic            step;      // do one bit step of the serial product
		logic            prep;      // reduce the cell's own coefficient
		logic [BitW-1:0] bit_idx;   // bit of the own coefficient during prep
		logic            a_bit;     // broadcast bit of the first operand
		logic            take_red;  // keep the reduced coefficient
		logic            clr_acc;   // clear the accumulator
		logic            shift;     // accumulators move one cell toward the output
		logic            add_term;  // fold the finished product into the sum
	} cell_ctrl_t;

	// One step of an MSB-first modular multiply: (2r + b*m) mod p, for r < p, m < p.
	function automatic logic [CoefW-1:0] mod_step(
		input logic [CoefW-1:0] r,
		input logic             b,
		input logic [CoefW-1:0] m,
		input logic [CoefW-1:0] p
	);
		logic [CoefW:0] t;
		logic [CoefW:0] u;
		t = {r, 1'b0};
		if (t >= {1'b0, p}) begin
			t = t - {1'b0, p};
		end
		u = t + {1'b0, (b ? m : {CoefW{1'b0}})};
		if (u >= {1'b0, p}) begin
			u = u - {1'b0, p};
		end
		return u[CoefW-1:0];
	endfunction

	// Modular addition of two values that are both below p.
	function automatic logic [CoefW-1:0] mod_add(
		input logic [CoefW-1:0] a,
		input logic [CoefW-1:0] b,
		input logic [CoefW-1:0] p
	);
		logic [CoefW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) begin
			s = s - {1'b0, p};
		end
		return s[CoefW-1:0];
	endfunction

endpackage

FILE: hw/rtl/pmm_in_if.sv
interface pmm_in_if;
	logic                          valid;
	logic                          ready;
	logic [pmm_pkg::CmdW-1:0]      cmd;
	logic [pmm_pkg::CoefW-1:0]     coef_in;

	modport source (output valid, cmd, coef_in, input ready);
	modport sink (input valid, cmd, coef_in, output ready);
endinterface

FILE: hw/rtl/pmm_out_if.sv
interface pmm_out_if;
	logic                          valid;
	logic                          ready;
	logic [pmm_pkg::CoefW-1:0]     product_coef;
	logic                          last;

	modport source (output valid, product_coef, last, input ready);
	modport sink (input valid, product_coef, last, output ready);
endinterface

FILE: hw/rtl/pmm_cell.sv
module pmm_cell (
	input  logic                       clk,
	input  pmm_pkg::cell_ctrl_t        ctrl,
	input  logic [pmm_pkg::CoefW-1:0]  modulus,
	input  logic                       active,
	input  logic                       b_we,
	input  logic [pmm_pkg::CoefW-1:0]  b_wdata,
	input  logic [pmm_pkg::CoefW-1:0]  acc_in,
	output logic [pmm_pkg::CoefW-1:0]  acc_out
);

	logic [pmm_pkg::CoefW-1:0] b_q;
	logic [pmm_pkg::CoefW-1:0] bred_q;
	logic [pmm_pkg::CoefW-1:0] r_q;
	logic [pmm_pkg::CoefW-1:0] acc_q;
	logic [pmm_pkg::CoefW-1:0] mult;
	logic                      bit_val;
	logic [pmm_pkg::CoefW-1:0] r_next;
	logic [pmm_pkg::CoefW-1:0] term;

	// During prep the cell reduces its own coefficient as own * 1 mod p.
	assign mult    = ctrl.prep ? pmm_pkg::CoefOne : bred_q;
	assign bit_val = ctrl.prep ? b_q[ctrl.bit_idx] : ctrl.a_bit;
	assign r_next  = pmm_pkg::mod_step(r_q, bit_val, mult, modulus);

	// Cells beyond the second operand's length contribute nothing.
	assign term    = (ctrl.add_term && active) ? r_q : '0;
	assign acc_out = pmm_pkg::mod_add(acc_q, term, modulus);

	// Stored coefficient of the second operand.
	always_ff @(posedge clk) begin
		if (b_we) begin
			b_q <= b_wdata;
		end
	end

	// Serial modular product and the reduced coefficient.
	always_ff @(posedge clk) begin
		if (ctrl.clr_r) begin
			r_q <= '0;
		end else if (ctrl.step) begin
			r_q <= r_next;
		end
		if (ctrl.take_red) begin
			bred_q <= r_q;
		end
	end

	// Partial sum for one product degree; it moves to the lower neighbor on each transfer.
	always_ff @(posedge clk) begin
		if (ctrl.clr_acc) begin
			acc_q <= '0;
		end else if (ctrl.shift) begin
			acc_q <= acc_in;
		end
	end

endmodule

FILE: hw/rtl/poly_mul_mod_p_top.sv
// Polynomial product over Z/pZ. The first operand sits in a register file and the second in a
// row of MAX_TERMS cells, one coefficient per cell; each cell holds one partial sum of the
// product and passes it to its lower neighbor whenever a product coefficient leaves the block.
// On a load the coefficient is reduced modulo p by a bit-serial unit, one bit per cycle, before
// it is stored. On a start with lengths n1 and n2 the cells first reduce the stored second
// operand modulo the current p, then each first-operand coefficient is multiplied into all cells
// at once by the cells' serial modular multipliers (26 bit steps and one transfer), and the
// last n2 - 1 coefficients drain from the chain one a cycle while the output is not stalled.
// A start with an empty operand emits nothing. A modulus value below 2 is stored as 2.
module poly_mul_mod_p_top #(
	parameter int MAX_TERMS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       modulus_we,
	input  logic [pmm_pkg::CoefW-1:0]  modulus_wdata,
	pmm_in_if.sink                     in_ch,
	pmm_out_if.source                  out_ch
);

	localparam int LenW = $clog2(MAX_TERMS + 1);
	localparam int IdxW = $clog2(MAX_TERMS);
	localparam logic [LenW-1:0] MaxLen = LenW'(MAX_TERMS);
	localparam logic [LenW-1:0] OneLen = LenW'(1);

	pmm_pkg::state_t           state_q;
	pmm_pkg::state_t           state_d;
	pmm_pkg::cell_ctrl_t       ctrl;

	logic [pmm_pkg::CoefW-1:0] mod_q;
	logic [LenW-1:0]           len1_q;
	logic [LenW-1:0]           len2_q;
	logic [LenW-1:0]           n1_q;
	logic [LenW-1:0]           n2_q;
	logic [LenW-1:0]           fl_q;
	logic [IdxW-1:0]           i_q;
	logic [pmm_pkg::BitW-1:0]  bit_q;
	logic                      tgt_second_q;
	logic [pmm_pkg::CoefW-1:0] coef_q;
	logic [pmm_pkg::CoefW-1:0] red_q;
	logic [pmm_pkg::CoefW-1:0] red_next;
	logic [pmm_pkg::CoefW-1:0] a_q [MAX_TERMS];

	logic                      out_valid_q;
	logic [pmm_pkg::CoefW-1:0] out_coef_q;
	logic                      out_last_q;

	logic                      accept;
	logic                      slot_free;
	logic                      bit_last;
	logic                      i_last;
	logic                      load_wr;
	logic                      out_load;
	logic                      out_last_d;

	logic [pmm_pkg::CoefW-1:0] acc_link [MAX_TERMS+1];

	assign accept    = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;
	assign bit_last  = (bit_q == '0);
	assign i_last    = ({{(LenW-IdxW){1'b0}}, i_q} == (n1_q - OneLen));
	assign red_next  = pmm_pkg::mod_step(red_q, coef_q[bit_q], pmm_pkg::CoefOne, mod_q);

	assign in_ch.ready         = (state_q == pmm_pkg::ST_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.product_coef = out_coef_q;
	assign out_ch.last         = out_last_q;

	// Modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= pmm_pkg::MinModulus;
		end else if (modulus_we) begin
			mod_q <= (modulus_wdata < pmm_pkg::MinModulus) ? pmm_pkg::MinModulus : modulus_wdata;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmm_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_ch.cmd)
						pmm_pkg::CMD_LOAD_FIRST: begin
							if (len1_q < MaxLen) begin
								state_d = pmm_pkg::ST_LOAD;
							end
						end
						pmm_pkg::CMD_LOAD_SECOND: begin
							if (len2_q < MaxLen) begin
								state_d = pmm_pkg::ST_LOAD;
							end
						end
						pmm_pkg::CMD_START: begin
							if (len1_q != '0 && len2_q != '0) begin
								state_d = pmm_pkg::ST_PREP;
							end
						end
						default: state_d = pmm_pkg::ST_IDLE;
					endcase
				end
			end
			pmm_pkg::ST_LOAD: begin
				if (bit_last) begin
					state_d = pmm_pkg::ST_IDLE;
				end
			end
			pmm_pkg::ST_PREP: begin
				if (bit_last) begin
					state_d = pmm_pkg::ST_PREP_DONE;
				end
			end
			pmm_pkg::ST_PREP_DONE: state_d = pmm_pkg::ST_MUL;
			pmm_pkg::ST_MUL: begin
				if (bit_last) begin
					state_d = pmm_pkg::ST_EMIT;
				end
			end
			pmm_pkg::ST_EMIT: begin
				if (slot_free) begin
					if (!i_last) begin
						state_d = pmm_pkg::ST_MUL;
					end else if (n2_q == OneLen) begin
						state_d = pmm_pkg::ST_IDLE;
					end else begin
						state_d = pmm_pkg::ST_FLUSH;
					end
				end
			end
			pmm_pkg::ST_FLUSH: begin
				if (slot_free && fl_q == OneLen) begin
					state_d = pmm_pkg::ST_IDLE;
				end
			end
			default: state_d = pmm_pkg::ST_IDLE;
		endcase
	end

	// Output logic: cell controls, operand writes and output register loads.
	always_comb begin
		ctrl       = '0;
		load_wr    = 1'b0;
		out_load   = 1'b0;
		out_last_d = 1'b0;
		ctrl.bit_idx = bit_q;
		ctrl.a_bit   = a_q[i_q][bit_q];
		case (state_q)
			pmm_pkg::ST_IDLE: begin
				if (accept && in_ch.cmd == pmm_pkg::CMD_START) begin
					ctrl.clr_r   = 1'b1;
					ctrl.clr_acc = 1'b1;
				end
			end
			pmm_pkg::ST_LOAD: begin
				load_wr = bit_last;
			end
			pmm_pkg::ST_PREP: begin
				ctrl.step = 1'b1;
				ctrl.prep = 1'b1;
			end
			pmm_pkg::ST_PREP_DONE: begin
				ctrl.take_red = 1'b1;
				ctrl.clr_r    = 1'b1;
			end
			pmm_pkg::ST_MUL: begin
				ctrl.step = 1'b1;
			end
			pmm_pkg::ST_EMIT: begin
				ctrl.add_term = 1'b1;
				if (slot_free) begin
					ctrl.shift = 1'b1;
					ctrl.clr_r = 1'b1;
					out_load   = 1'b1;
					out_last_d = i_last && (n2_q == OneLen);
				end
			end
			pmm_pkg::ST_FLUSH: begin
				if (slot_free) begin
					ctrl.shift = 1'b1;
					out_load   = 1'b1;
					out_last_d = (fl_q == OneLen);
				end
			end
			default: ctrl = '0;
		endcase
	end

	// Sequencer state, lengths and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pmm_pkg::ST_IDLE;
			len1_q       <= '0;
			len2_q       <= '0;
			n1_q         <= '0;
			n2_q         <= '0;
			fl_q         <= '0;
			i_q          <= '0;
			bit_q        <= '0;
			tgt_second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_q        <= pmm_pkg::TopBit;
				tgt_second_q <= (in_ch.cmd == pmm_pkg::CMD_LOAD_SECOND);
				if (in_ch.cmd == pmm_pkg::CMD_START) begin
					n1_q   <= len1_q;
					n2_q   <= len2_q;
					len1_q <= '0;
					len2_q <= '0;
				end
			end
			if (state_q == pmm_pkg::ST_LOAD || state_q == pmm_pkg::ST_PREP ||
			    state_q == pmm_pkg::ST_MUL) begin
				bit_q <= bit_q - 1'b1;
			end
			if (load_wr) begin
				if (tgt_second_q) begin
					len2_q <= len2_q + OneLen;
				end else begin
					len1_q <= len1_q + OneLen;
				end
			end
			if (state_q == pmm_pkg::ST_PREP_DONE) begin
				i_q   <= '0;
				bit_q <= pmm_pkg::TopBit;
			end
			if (state_q == pmm_pkg::ST_EMIT && slot_free) begin
				i_q   <= i_q + 1'b1;
				bit_q <= pmm_pkg::TopBit;
				fl_q  <= n2_q - OneLen;
			end
			if (state_q == pmm_pkg::ST_FLUSH && slot_free) begin
				fl_q <= fl_q - OneLen;
			end
		end
	end

	// Load reduction: the coefficient is reduced modulo p one bit per cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			coef_q <= in_ch.coef_in;
			red_q  <= '0;
		end else if (state_q == pmm_pkg::ST_LOAD) begin
			red_q <= red_next;
		end
	end

	// First operand register file.
	always_ff @(posedge clk) begin
		if (load_wr && !tgt_second_q) begin
			a_q[len1_q[IdxW-1:0]] <= red_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_coef_q <= acc_link[0];
			out_last_q <= out_last_d;
		end
	end

	// Chain of cells; the highest cell takes in an empty partial sum.
	assign acc_link[MAX_TERMS] = '0;

	for (genvar j = 0; j < MAX_TERMS; j++) begin : g_cell
		logic cell_we;
		logic cell_active;

		assign cell_we     = load_wr && tgt_second_q && (len2_q == LenW'(j));
		assign cell_active = (LenW'(j) < n2_q);

		pmm_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.modulus (mod_q),
			.active  (cell_active),
			.b_we    (cell_we),
			.b_wdata (red_next),
			.acc_in  (acc_link[j+1]),
			.acc_out (acc_link[j])
		);
	end

endmodule
